/* design/b64d_pkg.sv */
// Package: shared types, codes and the character decode function for the base64 decoder.
`default_nettype none
package b64d_pkg;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [7:0] ChPad   = 8'h3D;  // '='
  localparam logic [7:0] ChPlus  = 8'h2B;  // '+'
  localparam logic [7:0] ChSlash = 8'h2F;  // '/'
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_CHAR   = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sym_t;

  // One unit of work for the output side: a status or one decoded group.
  typedef struct packed {
    logic       is_status;
    status_t    status;
    logic [1:0] last_idx;  // index of the final byte of the group
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } entry_t;

  function automatic sym_t sym_decode(input logic [7:0] ch);
    sym_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    if (ch inside {[8'h41:8'h5A]}) begin
      s.val = 6'(ch - 8'd65);
    end else if (ch inside {[8'h61:8'h7A]}) begin
      s.val = 6'(ch - 8'd71);
    end else if (ch inside {[8'h30:8'h39]}) begin
      s.val = 6'(ch + 8'd4);
    end else if (ch == ChPlus) begin
      s.val = 6'd62;
    end else if (ch == ChSlash) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ch inside {ChCr, ChLf, ChSp, ChTab};
  endfunction

endpackage
`default_nettype wire

/* design/b64d_in_if.sv */
// Interface: character request channel into the decoder.
`default_nettype none
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_in;

  modport source (output valid, kind, char_in, input ready);
  modport sink   (input valid, kind, char_in, output ready);
endinterface
`default_nettype wire

/* design/b64d_out_if.sv */
// Interface: result request channel out of the decoder.
`default_nettype none
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_status;
  logic [1:0] status;
  logic       last_of_run;

  modport source (output valid, data_byte, is_status, status, last_of_run, input ready);
  modport sink   (input valid, data_byte, is_status, status, last_of_run, output ready);
endinterface
`default_nettype wire

/* design/b64d_front.sv */
// Front end: accepts characters, tracks the four-character group and builds work entries.
`default_nettype none
module b64d_front (
  input  wire logic            clk,
  input  wire logic            rst,
  b64d_in_if.sink              text,
  input  wire logic            q_full,
  output logic                 push,
  output b64d_pkg::entry_t     push_entry
);
  import b64d_pkg::*;

  logic [5:0] group_values [3];
  logic [1:0] group_count;
  logic [2:0] pad_count;
  logic       error_seen;

  logic       take;
  logic       is_pad;
  sym_t       sym;
  logic [5:0] v;
  logic [2:0] pad_new;
  logic       use_char;

  assign text.ready = !q_full;
  assign take       = text.valid && text.ready;
  assign is_pad     = (text.char_in == ChPad);
  assign sym        = sym_decode(text.char_in);
  assign v          = is_pad ? 6'd0 : sym.val;
  assign pad_new    = pad_count + {2'd0, is_pad};
  assign use_char   = take && !text.kind && !error_seen && !is_space(text.char_in);

  always_comb begin
    push_entry = '0;
    push       = 1'b0;
    if (take && text.kind) begin
      push                 = 1'b1;
      push_entry.is_status = 1'b1;
      push_entry.status    = error_seen ? ST_BAD_CHAR :
                             (group_count != 2'd0) ? ST_INCOMPLETE : ST_OK;
    end else if (use_char && (is_pad || sym.ok) && group_count == 2'd3) begin
      push          = 1'b1;
      push_entry.b0 = {group_values[0], group_values[1][5:4]};
      push_entry.b1 = {group_values[1][3:0], group_values[2][5:2]};
      push_entry.b2 = {group_values[2][1:0], v};
      if (pad_new == 3'd0) begin
        push_entry.last_idx = 2'd2;
      end else if (pad_new == 3'd1) begin
        push_entry.last_idx = 2'd1;
      end else begin
        push_entry.last_idx = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= 2'd0;
      pad_count   <= 3'd0;
      error_seen  <= 1'b0;
    end else if (take && text.kind) begin
      group_count <= 2'd0;
      pad_count   <= 3'd0;
      error_seen  <= 1'b0;
    end else if (use_char) begin
      if (!is_pad && !sym.ok) begin
        error_seen <= 1'b1;
      end else if (group_count == 2'd3) begin
        group_count <= 2'd0;
        pad_count   <= 3'd0;
      end else begin
        group_count <= group_count + 2'd1;
        pad_count   <= pad_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (use_char && (is_pad || sym.ok) && group_count != 2'd3) begin
      group_values[group_count] <= v;
    end
  end

  // The error flag only clears at an end of text or on reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    ($past(error_seen) && !$past(rst) && !$past(take && text.kind)) |-> error_seen)
    else $error("error flag dropped without end of text");

  // Nothing is pushed while the queue is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("push while queue full");

endmodule
`default_nettype wire

/* design/b64d_queue.sv */
// Queue: short FIFO of work entries between the front and back ends.
`default_nettype none
module b64d_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire b64d_pkg::entry_t push_entry,
  input  wire logic            pop,
  output b64d_pkg::entry_t     head,
  output logic                 full,
  output logic                 empty
);
  import b64d_pkg::*;

  entry_t          slots [QDepth];
  logic [QAw-1:0]  wr_ptr;
  logic [QAw-1:0]  rd_ptr;
  logic [QAw:0]    cnt;

  assign head  = slots[rd_ptr];
  assign full  = (cnt == (QAw+1)'(QDepth));
  assign empty = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QAw+1)'(QDepth))
    else $error("queue count overflow");

endmodule
`default_nettype wire

/* design/b64d_back.sv */
// Back end: walks the head entry and sends one result per cycle while the consumer is ready.
`default_nettype none
module b64d_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire b64d_pkg::entry_t head,
  input  wire logic            empty,
  output logic                 pop,
  b64d_out_if.source           result
);
  import b64d_pkg::*;

  logic [1:0] idx;
  logic       last;
  logic       send;

  assign last = head.is_status || (idx == head.last_idx);
  assign send = result.valid && result.ready;
  assign pop  = send && last;

  assign result.valid       = !empty;
  assign result.is_status   = head.is_status;
  assign result.status      = head.status;
  assign result.last_of_run = last;

  always_comb begin
    case (idx)
      2'd0:    result.data_byte = head.b0;
      2'd1:    result.data_byte = head.b1;
      default: result.data_byte = head.b2;
    endcase
    if (head.is_status) begin
      result.data_byte = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (send) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  // The byte index never passes the last byte of the entry being sent.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (!empty && !head.is_status) |-> (idx <= head.last_idx))
    else $error("byte index past end of group");

endmodule
`default_nettype wire

/* design/base64_stream_decoder_core.sv */
// Top level: base64 stream decoder built from front end, work queue and back end.
// Flow: a character that completes a group, or an end of text, is written into the queue,
//   and its results are sent from the queue head, the bytes of a group in order.
// Throughput: one character per cycle in, one result per cycle out while ready; the
//   4-entry queue absorbs output stalls, and the input stalls only when it is full.
// Reset: synchronous, active high; clears group state, error flag, queue and byte index.
`default_nettype none
module base64_stream_decoder_core (
  input  wire logic   clk,
  input  wire logic   rst,
  b64d_in_if.sink     text,
  b64d_out_if.source  result
);
  import b64d_pkg::*;

  // Work entries from the front end into the queue.
  logic   push;
  entry_t push_entry;

  // Queue head and occupancy toward both ends.
  entry_t head;
  logic   full;
  logic   empty;
  logic   pop;

  // Classify characters, hold the partial group, and push a request per finished
  // group or end of text.
  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .q_full     (full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple the two sides so a stalled consumer does not hold up the character stream
  // until the queue fills.
  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  // Drain each entry as one to three byte results, or a single status result.
  b64d_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule
`default_nettype wire
